// ===== sv/scrolling_ring_pixel_buffer_core_macros.svh =====
// Assertion macros shared by the pixel buffer RTL.
`ifndef SCROLLING_RING_PIXEL_BUFFER_CORE_MACROS_SVH
`define SCROLLING_RING_PIXEL_BUFFER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SRPB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SRPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SRPB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SRPB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/srpb_pkg.sv =====
// Package with the constants and types of the scrolling ring pixel buffer.
`default_nettype none
package srpb_pkg;
    localparam int COL_BITS = 7;
    localparam int ROW_BITS = 7;
    localparam int ADDR_W = COL_BITS + ROW_BITS;
    localparam int CNT_W = ADDR_W + 1;
    localparam int BUF_WIDTH = 1 << COL_BITS;
    localparam int BUF_HEIGHT = 1 << ROW_BITS;
    localparam int RING_SIZE = BUF_WIDTH * BUF_HEIGHT;

    typedef logic [15:0] pix_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam pix_t RESET_LEVEL = 16'h007F;
    localparam logic [15:0] BIAS_RESET = 16'h8000;

    localparam logic [1:0] REQ_PAN = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        pix_t  wr_data;
        logic  rd_en;
        addr_t rd_addr;
    } mem_req_t;
endpackage
`default_nettype wire

// ===== sv/srpb_req_if.sv =====
// Channel interfaces for requests and results of the pixel buffer.
`default_nettype none
interface srpb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] pan_dx;
    logic [15:0] pan_dy;
    logic [15:0] fill_value;
    logic [6:0]  region_x;
    logic [6:0]  region_y;
    logic [7:0]  region_w;
    logic [7:0]  region_h;
    logic [13:0] read_index;
    modport source (output valid, req_type, pan_dx, pan_dy, fill_value, region_x,
                    region_y, region_w, region_h, read_index, input ready);
    modport sink (input valid, req_type, pan_dx, pan_dy, fill_value, region_x,
                  region_y, region_w, region_h, read_index, output ready);
endinterface

interface srpb_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [15:0] scroll_bias;
    modport source (output valid, read_data, scroll_bias, input ready);
    modport sink (input valid, read_data, scroll_bias, output ready);
endinterface
`default_nettype wire

// ===== sv/srpb_store.sv =====
// Pixel store: one write port and one registered read port.
`default_nettype none
module srpb_store
    import srpb_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t mreq,
    output pix_t          rd_data
);
    pix_t mem [RING_SIZE];

    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr] <= mreq.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mreq.rd_en)
        begin
            rd_data <= mem[mreq.rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/scrolling_ring_pixel_buffer_core.sv =====
// Top level of the scrolling ring pixel buffer.
// A read's data is registered by the store at acceptance and moves to the result register in
// state S_FIN once any earlier result is taken. A pan or a clear writes its pixels one at a time
// through the single write port of the pixel store: a full pan fill all 16384, a column pan 128
// per exposed column. After reset the store is swept to level 127 before any request is taken.
`default_nettype none
`include "scrolling_ring_pixel_buffer_core_macros.svh"
module scrolling_ring_pixel_buffer_core
    import srpb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    srpb_req_if.sink    req,
    srpb_rsp_if.source  rsp,
    input  wire logic   psel,
    input  wire logic   penable,
    input  wire logic   pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [1:0] {S_RUN, S_IDLE, S_FIN} state_t;

    state_t         state_reg;
    logic           init_reg;
    logic           pend_reg;
    logic           colwrap_reg;
    logic           is_read_reg;
    addr_t          base_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] k_reg;
    logic [7:0]     rows_reg;
    pix_t           val_reg;
    addr_t          sp_start_reg;
    logic [CNT_W-1:0] sp_cnt_reg;
    addr_t          origin_reg;
    logic [15:0]    bias_reg;
    pix_t           neutral_reg;
    logic           out_valid_reg;
    pix_t           out_data_reg;
    logic [15:0]    out_bias_reg;

    mem_req_t       mreq;
    pix_t           rd_data;
    logic           acc;
    logic [16:0]    adx;
    logic [16:0]    ady;
    logic           big;
    addr_t          o1;
    addr_t          o2;
    logic [COL_BITS-1:0] col_start;
    addr_t          clr_base;
    logic           last_k;

    srpb_store u_store (.clk(clk), .mreq(mreq), .rd_data(rd_data));

    assign pready = 1'b1;
    assign prdata = {16'h0000, neutral_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_reg <= RESET_LEVEL;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            neutral_reg <= pwdata[15:0];
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign acc = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.scroll_bias = out_bias_reg;

    assign adx = req.pan_dx[15] ? 17'(-$signed({req.pan_dx[15], req.pan_dx}))
                                : {1'b0, req.pan_dx};
    assign ady = req.pan_dy[15] ? 17'(-$signed({req.pan_dy[15], req.pan_dy}))
                                : {1'b0, req.pan_dy};
    assign big = (adx > 17'(BUF_WIDTH)) || (ady > 17'(BUF_HEIGHT));
    assign o1 = origin_reg + req.pan_dx[ADDR_W-1:0];
    assign o2 = o1 + {req.pan_dy[ROW_BITS-1:0], {COL_BITS{1'b0}}};
    assign col_start = req.pan_dx[15] ? origin_reg[COL_BITS-1:0] + req.pan_dx[COL_BITS-1:0]
                                      : origin_reg[COL_BITS-1:0];
    assign clr_base = {req.region_y, {COL_BITS{1'b0}}} + addr_t'(req.region_x) + origin_reg;
    assign last_k = (k_reg == cnt_reg - 1'b1);

    always_comb
    begin
        mreq.wr_en = (state_reg == S_RUN);
        mreq.wr_data = val_reg;
        if (colwrap_reg)
        begin
            mreq.wr_addr = {base_reg[ADDR_W-1:COL_BITS],
                            base_reg[COL_BITS-1:0] + k_reg[COL_BITS-1:0]};
        end
        else
        begin
            mreq.wr_addr = base_reg + k_reg[ADDR_W-1:0];
        end
        mreq.rd_en = acc && (req.req_type == REQ_READ);
        mreq.rd_addr = origin_reg + req.read_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            init_reg <= 1'b1;
            pend_reg <= 1'b0;
            colwrap_reg <= 1'b0;
            is_read_reg <= 1'b0;
            base_reg <= '0;
            cnt_reg <= CNT_W'(RING_SIZE);
            k_reg <= '0;
            rows_reg <= 8'd1;
            val_reg <= RESET_LEVEL;
            sp_start_reg <= '0;
            sp_cnt_reg <= '0;
            origin_reg <= '0;
            bias_reg <= BIAS_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_bias_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        is_read_reg <= (req.req_type == REQ_READ);
                        k_reg <= '0;
                        state_reg <= S_FIN;
                        pend_reg <= 1'b0;
                        if (req.req_type == REQ_PAN)
                        begin
                            val_reg <= req.fill_value;
                            if (big)
                            begin
                                bias_reg <= BIAS_RESET;
                                colwrap_reg <= 1'b0;
                                base_reg <= '0;
                                cnt_reg <= CNT_W'(RING_SIZE);
                                rows_reg <= 8'd1;
                                state_reg <= S_RUN;
                            end
                            else
                            begin
                                origin_reg <= o2;
                                bias_reg <= bias_reg - req.pan_dy;
                                sp_start_reg <= req.pan_dy[15] ? o2 : o1;
                                sp_cnt_reg <= {ady[7:0], {COL_BITS{1'b0}}};
                                if (req.pan_dx != '0)
                                begin
                                    colwrap_reg <= 1'b1;
                                    base_reg <= addr_t'(col_start);
                                    cnt_reg <= CNT_W'(adx[7:0]);
                                    rows_reg <= 8'(BUF_HEIGHT);
                                    pend_reg <= (req.pan_dy != '0);
                                    state_reg <= S_RUN;
                                end
                                else if (req.pan_dy != '0)
                                begin
                                    colwrap_reg <= 1'b0;
                                    base_reg <= req.pan_dy[15] ? o2 : o1;
                                    cnt_reg <= {ady[7:0], {COL_BITS{1'b0}}};
                                    rows_reg <= 8'd1;
                                    state_reg <= S_RUN;
                                end
                            end
                        end
                        else if (req.req_type == REQ_CLEAR)
                        begin
                            val_reg <= neutral_reg;
                            colwrap_reg <= 1'b0;
                            base_reg <= clr_base;
                            cnt_reg <= CNT_W'(req.region_w);
                            rows_reg <= req.region_h;
                            if ((req.region_w != '0) && (req.region_h != '0))
                            begin
                                state_reg <= S_RUN;
                            end
                        end
                    end
                end
                S_RUN:
                begin
                    if (last_k)
                    begin
                        k_reg <= '0;
                        if (rows_reg == 8'd1)
                        begin
                            if (pend_reg)
                            begin
                                pend_reg <= 1'b0;
                                colwrap_reg <= 1'b0;
                                base_reg <= sp_start_reg;
                                cnt_reg <= sp_cnt_reg;
                            end
                            else if (init_reg)
                            begin
                                init_reg <= 1'b0;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        else
                        begin
                            rows_reg <= rows_reg - 8'd1;
                            base_reg <= base_reg + addr_t'(BUF_WIDTH);
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= is_read_reg ? rd_data : '0;
                        out_bias_reg <= bias_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SRPB_ASSERT_SAME(a_no_accept_busy, clk, rst_n, state_reg == S_RUN, !req.ready)
    `SRPB_ASSERT_NEXT(a_read_direct, clk, rst_n, acc && (req.req_type == REQ_READ), state_reg == S_FIN)
    `SRPB_ASSERT_NEXT(a_origin_hold, clk, rst_n, !acc, $stable(origin_reg))
    `SRPB_ASSERT_SAME(a_init_only_run, clk, rst_n, init_reg, state_reg == S_RUN && !out_valid_reg)
endmodule
`default_nettype wire

// ===== verif/scrolling_ring_pixel_buffer_core_test.sv =====
// Self-checking testbench for the scrolling ring pixel buffer: pans, clears and reads.
`timescale 1ns / 1ps
module scrolling_ring_pixel_buffer_core_test;
    import srpb_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [2:0] ADDR_NEUTRAL = 3'd0;
    localparam int STALL_LIMIT = 100000;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] fill;
        logic [6:0]  rx;
        logic [6:0]  ry;
        logic [7:0]  rw;
        logic [7:0]  rh;
        logic [13:0] idx;
        bit          typed;
        logic [15:0] want_data;
        logic [15:0] want_bias;
    } buf_req_t;

    typedef struct {
        logic [15:0] data;
        logic [15:0] bias;
    } buf_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    srpb_req_if req_ch();
    srpb_rsp_if rsp_ch();

    scrolling_ring_pixel_buffer_core dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 clk = ~clk;

    pix_t shadow_store [RING_SIZE];
    int shadow_origin;
    logic [15:0] shadow_bias;
    pix_t shadow_neutral;

    buf_rsp_t pending_results[$];
    int errors = 0;
    int tx_idle = 0;
    int rx_idle = 0;
    int stall_count = 0;
    int beats_out = 0;
    int pans = 0;
    int clears = 0;
    int reads = 0;

    function automatic int wrap_ring(int v);
        int r;
        r = v % RING_SIZE;
        if (r < 0)
            r += RING_SIZE;
        return r;
    endfunction

    task automatic fill_span(int start, int count, pix_t v);
        int p;
        p = start % RING_SIZE;
        if (count > RING_SIZE)
            count = RING_SIZE;
        for (int i = 0; i < count; i++)
        begin
            shadow_store[p] = v;
            p = (p + 1) % RING_SIZE;
        end
    endtask

    task automatic fill_cols(int c0, int c1, pix_t v);
        if (c0 < 0)
            c0 = 0;
        if (c1 > BUF_WIDTH)
            c1 = BUF_WIDTH;
        for (int r = 0; r < BUF_HEIGHT; r++)
            for (int c = c0; c < c1; c++)
                shadow_store[r * BUF_WIDTH + c] = v;
    endtask

    task automatic pan_view(int dx, int dy, pix_t v);
        int col;
        int tcol;
        int row;
        int trow;
        int prev;
        if ((dx < 0 ? -dx : dx) > BUF_WIDTH || (dy < 0 ? -dy : dy) > BUF_HEIGHT)
        begin
            fill_span(0, RING_SIZE, v);
            shadow_bias = BIAS_RESET;
            return;
        end
        col = shadow_origin % BUF_WIDTH;
        tcol = col + dx;
        if (dx != 0)
        begin
            shadow_origin = wrap_ring(shadow_origin + dx);
            if (dx < 0)
            begin
                if (tcol < 0)
                begin
                    fill_cols(0, col, v);
                    fill_cols(tcol + BUF_WIDTH, BUF_WIDTH, v);
                end
                else
                    fill_cols(tcol, col, v);
            end
            else if (tcol >= BUF_WIDTH)
            begin
                fill_cols(col, BUF_WIDTH, v);
                fill_cols(0, tcol - BUF_WIDTH, v);
            end
            else
                fill_cols(col, tcol, v);
        end
        if (dy != 0)
        begin
            row = shadow_origin / BUF_WIDTH;
            trow = row + dy;
            shadow_bias = shadow_bias - 16'(dy);
            prev = shadow_origin;
            shadow_origin = wrap_ring(shadow_origin + dy * BUF_WIDTH);
            if (dy < 0)
            begin
                if (trow < 0)
                begin
                    fill_span(0, prev, v);
                    fill_span(shadow_origin, RING_SIZE - shadow_origin, v);
                end
                else
                    fill_span(shadow_origin, prev - shadow_origin, v);
            end
            else if (trow >= BUF_HEIGHT)
            begin
                fill_span(prev, RING_SIZE - prev, v);
                fill_span(0, shadow_origin, v);
            end
            else
                fill_span(prev, shadow_origin - prev, v);
        end
    endtask

    task automatic clear_region(int x, int y, int w, int h);
        int p;
        p = wrap_ring(y * BUF_WIDTH + x + shadow_origin);
        for (int i = 0; i < h; i++)
        begin
            fill_span(p, w, shadow_neutral);
            p = wrap_ring(p + BUF_WIDTH);
        end
    endtask

    task automatic apply_request(buf_req_t it, output buf_rsp_t res);
        res.data = '0;
        case (it.kind)
            REQ_PAN:
            begin
                pan_view(int'($signed(it.dx)), int'($signed(it.dy)), it.fill);
                pans++;
            end
            REQ_CLEAR:
            begin
                clear_region(it.rx, it.ry, it.rw, it.rh);
                clears++;
            end
            REQ_READ:
            begin
                res.data = shadow_store[wrap_ring(shadow_origin + it.idx)];
                reads++;
            end
            default: ;
        endcase
        res.bias = shadow_bias;
    endtask

    function automatic buf_req_t mk(logic [1:0] kind, int dx, int dy, int fill,
                                    int rx, int ry, int rw, int rh, int idx,
                                    bit typed = 0, int wd = 0, int wb = 0);
        buf_req_t it;
        it.kind = kind;
        it.dx = 16'(dx);
        it.dy = 16'(dy);
        it.fill = 16'(fill);
        it.rx = 7'(rx);
        it.ry = 7'(ry);
        it.rw = 8'(rw);
        it.rh = 8'(rh);
        it.idx = 14'(idx);
        it.typed = typed;
        it.want_data = 16'(wd);
        it.want_bias = 16'(wb);
        return it;
    endfunction

    function automatic buf_req_t random_request();
        int pick;
        buf_req_t it;
        pick = $urandom_range(99);
        it = mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        it.dx = 16'($urandom);
        it.dy = 16'($urandom);
        it.fill = 16'($urandom);
        it.rx = 7'($urandom);
        it.ry = 7'($urandom);
        it.rw = 8'($urandom_range(128));
        it.rh = 8'($urandom_range(128));
        it.idx = 14'($urandom);
        if (pick < 45)
            it.kind = REQ_READ;
        else if (pick < 72)
        begin
            it.kind = REQ_PAN;
            it.dx = 16'($signed($urandom_range(8)) - 4);
            it.dy = 16'($signed($urandom_range(6)) - 3);
        end
        else if (pick < 74)
        begin
            it.kind = REQ_PAN;
            it.dx = 16'($signed($urandom_range(256)) - 128);
            it.dy = '0;
        end
        else if (pick < 76)
            it.kind = REQ_PAN;
        else if (pick < 95)
        begin
            it.kind = REQ_CLEAR;
            it.rw = 8'($urandom_range(8));
            it.rh = 8'($urandom_range(8));
        end
        else if (pick < 97)
            it.kind = REQ_CLEAR;
        else
            it.kind = REQ_NONE;
        return it;
    endfunction

    task automatic send_request(buf_req_t it);
        buf_rsp_t res;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.req_type = it.kind;
        req_ch.pan_dx = it.dx;
        req_ch.pan_dy = it.dy;
        req_ch.fill_value = it.fill;
        req_ch.region_x = it.rx;
        req_ch.region_y = it.ry;
        req_ch.region_w = it.rw;
        req_ch.region_h = it.rh;
        req_ch.read_index = it.idx;
        do @(posedge clk); while (!req_ch.ready);
        apply_request(it, res);
        if (it.typed)
        begin
            res.data = it.want_data;
            res.bias = it.want_bias;
        end
        pending_results.push_back(res);
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_neutral(logic [15:0] level);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_NEUTRAL;
        pwdata = {16'h0, level};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        shadow_neutral = level;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            beats_out++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                if (rsp_ch.read_data !== pending_results[0].data)
                begin
                    $error("read_data expected %h actual %h",
                           pending_results[0].data, rsp_ch.read_data);
                    errors++;
                end
                if (rsp_ch.scroll_bias !== pending_results[0].bias)
                begin
                    $error("scroll_bias expected %h actual %h",
                           pending_results[0].bias, rsp_ch.scroll_bias);
                    errors++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("scrolling_ring_pixel_buffer_core: mismatch");
            $finish;
        end
    end

    buf_req_t directed [$];

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PAN;
        req_ch.pan_dx = '0;
        req_ch.pan_dy = '0;
        req_ch.fill_value = '0;
        req_ch.region_x = '0;
        req_ch.region_y = '0;
        req_ch.region_w = '0;
        req_ch.region_h = '0;
        req_ch.read_index = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < RING_SIZE; i++)
            shadow_store[i] = RESET_LEVEL;
        shadow_origin = 0;
        shadow_bias = BIAS_RESET;
        shadow_neutral = RESET_LEVEL;

        directed.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 'h7F, 'h8000));
        directed.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 16383, 1, 'h7F, 'h8000));
        directed.push_back(mk(REQ_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 'h8000));
        directed.push_back(mk(REQ_PAN, 129, 0, 'hFFFF, 0, 0, 0, 0, 0, 1, 0, 'h8000));
        directed.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 5, 1, 'hFFFF, 'h8000));
        directed.push_back(mk(REQ_PAN, 0, -129, 0, 0, 0, 0, 0, 0, 1, 0, 'h8000));
        directed.push_back(mk(REQ_PAN, -32768, 32767, 'h1234, 0, 0, 0, 0, 0, 1, 0, 'h8000));
        directed.push_back(mk(REQ_PAN, 128, 0, 'hAAAA, 0, 0, 0, 0, 0, 1, 0, 'h8000));
        directed.push_back(mk(REQ_PAN, -3, 0, 'h5555, 0, 0, 0, 0, 0));
        directed.push_back(mk(REQ_PAN, 5, 2, 'h0F0F, 0, 0, 0, 0, 0));
        directed.push_back(mk(REQ_PAN, 0, -128, 'h00FF, 0, 0, 0, 0, 0));
        directed.push_back(mk(REQ_PAN, -128, 128, 'hF00D, 0, 0, 0, 0, 0));
        directed.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 16383));
        directed.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 128, 128, 0));
        directed.push_back(mk(REQ_PAN, 3, -2, 'h8001, 0, 0, 0, 0, 0));
        directed.push_back(mk(REQ_CLEAR, 0, 0, 0, 127, 127, 1, 1, 0));
        directed.push_back(mk(REQ_CLEAR, 0, 0, 0, 10, 3, 0, 5, 0));
        directed.push_back(mk(REQ_CLEAR, 0, 0, 0, 5, 9, 128, 1, 0));
        directed.push_back(mk(REQ_CLEAR, 0, 0, 0, 126, 0, 3, 128, 0));
        directed.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 16383));
        directed.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1000));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        tx_idle = 11;
        rx_idle = 59;
        foreach (directed[i])
            send_request(directed[i]);
        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0: write_neutral(16'h0000);
                1: write_neutral(16'hFFFF);
                default: write_neutral(16'($urandom));
            endcase
            tx_idle = (phase == 0) ? 11 : (phase == 1) ? 59 : 0;
            rx_idle = (phase == 0) ? 59 : (phase == 1) ? 11 : 0;
            for (int n = 0; n < 134; n++)
                send_request(random_request());
        end
        @(negedge clk);
        req_ch.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(posedge clk);

        $display("Covered %0d pans, %0d clears and %0d reads; %0d result beats checked.",
                 pans, clears, reads, beats_out);
        $display("Neutral level written at both extremes and a random value.");
        if (errors == 0)
            $display("scrolling_ring_pixel_buffer_core: match");
        else
            $display("scrolling_ring_pixel_buffer_core: mismatch");
        $finish;
    end
endmodule
